// ===== design/fpm3_pkg.sv =====
// ----------------------------------------------------------------------------
// fpm3_pkg: shared types and constants for the 3x3 fixed-point matrix multiply
// Matrix dimension, field widths, register map and sequencer state type.
// ----------------------------------------------------------------------------
package fpm3_pkg;

  localparam int DIM            = 3;
  localparam int CELLS          = DIM * DIM;
  localparam int CELL_W         = $clog2(CELLS);
  localparam int IDX_W          = 2;
  localparam int FIELD_W        = 32;
  localparam int FRAC_W         = 5;
  localparam int SHIFT_W        = FRAC_W + 1;
  localparam int PROD_W         = 64;
  localparam int DEF_ELEMENT_W  = 32;
  localparam int APB_ADDR_W     = 4;
  localparam int APB_DATA_W     = 32;

  localparam logic [FRAC_W-1:0] FRAC_RESET = FRAC_W'(16);
  localparam logic [IDX_W-1:0]  LAST_IDX   = IDX_W'(DIM - 1);

  typedef enum logic [1:0] {
    REG_A_FRAC   = 2'd0,
    REG_B_FRAC   = 2'd1,
    REG_RES_FRAC = 2'd2,
    REG_NONE     = 2'd3
  } fpm3_reg_t;

  typedef enum logic {
    ACT_LOAD     = 1'b0,
    ACT_MULTIPLY = 1'b1
  } fpm3_action_t;

  typedef enum logic {
    MAT_A = 1'b0,
    MAT_B = 1'b1
  } fpm3_matrix_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_RUN  = 1'b1
  } fpm3_state_t;

  // tag that travels with each product through the MAC pipeline
  typedef struct packed {
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic             first;
    logic             elem_last;
    logic             mat_last;
  } fpm3_tag_t;

  function automatic logic [CELL_W-1:0] cell_idx(input logic [IDX_W-1:0] row,
                                                 input logic [IDX_W-1:0] col);
    logic [CELL_W-1:0] r_ext;
    logic [CELL_W-1:0] c_ext;
    r_ext = CELL_W'(row);
    c_ext = CELL_W'(col);
    return CELL_W'(r_ext * CELL_W'(DIM)) + c_ext;
  endfunction

endpackage

// ===== design/fixed_point_matrix3_multiply_top.sv =====
// ----------------------------------------------------------------------------
// fixed_point_matrix3_multiply_top: 3x3 signed fixed-point matrix multiply
// Holds matrices A and B, and on request streams C = A * B in row-major order.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall): a load request writes one element of A
// or B; a load at row or column 3 is dropped. A multiply request starts the
// sequencer, which pushes the 27 products through one shared multiplier, one
// product per cycle unless the output stalls: operand read, multiply, then
// fraction shift and accumulate. in_stall stays high after a multiply is
// accepted until the sequencer has issued its last product. Every third
// product completes a result; the ninth result carries out_last.
// Result channel (out_valid / out_stall): one output register. While it holds
// a result and out_stall is high, the whole MAC pipeline and the issue
// counters freeze, so nothing is dropped.
// Config port (APB, pready tied high): fraction-bit registers for A, B and
// the result at byte addresses 0, 4, 8. Write them only while idle.
// Reset clears control state and sets all fraction counts to 16; the matrix
// stores are undefined until loaded.
// ----------------------------------------------------------------------------
module fixed_point_matrix3_multiply_top #(
  parameter int ELEMENT_WIDTH = fpm3_pkg::DEF_ELEMENT_W
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // input requests
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               in_action,
  input  logic                               in_which_matrix,
  input  logic [fpm3_pkg::IDX_W-1:0]         in_row_index,
  input  logic [fpm3_pkg::IDX_W-1:0]         in_col_index,
  input  logic signed [fpm3_pkg::FIELD_W-1:0] in_element_value,
  // results
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [fpm3_pkg::IDX_W-1:0]         out_row,
  output logic [fpm3_pkg::IDX_W-1:0]         out_col,
  output logic signed [fpm3_pkg::FIELD_W-1:0] out_value,
  output logic                               out_last,
  // configuration
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [fpm3_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [fpm3_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [fpm3_pkg::APB_DATA_W-1:0]    prdata,
  output logic                               pready
);

  import fpm3_pkg::*;

  localparam int EW = ELEMENT_WIDTH;
  localparam int PW = 2 * EW;

  // ---------------- configuration registers ----------------
  logic [FRAC_W-1:0] a_frac_r, b_frac_r, res_frac_r;
  fpm3_reg_t         reg_sel;
  logic              cfg_wr;

  assign reg_sel = fpm3_reg_t'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_frac_r   <= FRAC_RESET;
      b_frac_r   <= FRAC_RESET;
      res_frac_r <= FRAC_RESET;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_A_FRAC:   a_frac_r   <= pwdata[FRAC_W-1:0];
        REG_B_FRAC:   b_frac_r   <= pwdata[FRAC_W-1:0];
        REG_RES_FRAC: res_frac_r <= pwdata[FRAC_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_A_FRAC:   prdata = APB_DATA_W'(a_frac_r);
      REG_B_FRAC:   prdata = APB_DATA_W'(b_frac_r);
      REG_RES_FRAC: prdata = APB_DATA_W'(res_frac_r);
      default:      prdata = '0;
    endcase
  end

  // ---------------- matrix stores ----------------
  logic [EW-1:0] a_mem [CELLS];
  logic [EW-1:0] b_mem [CELLS];

  logic in_acc, load_ok;
  assign in_acc  = in_valid && !in_stall;
  assign load_ok = in_acc && (fpm3_action_t'(in_action) == ACT_LOAD)
                   && (in_row_index <= LAST_IDX) && (in_col_index <= LAST_IDX);

  always_ff @(posedge clk) begin
    if (load_ok) begin
      if (fpm3_matrix_t'(in_which_matrix) == MAT_A) begin
        a_mem[cell_idx(in_row_index, in_col_index)] <= EW'(in_element_value);
      end else begin
        b_mem[cell_idx(in_row_index, in_col_index)] <= EW'(in_element_value);
      end
    end
  end

  // ---------------- sequencer ----------------
  fpm3_state_t      state_r, state_nxt;
  logic [IDX_W-1:0] r_r, c_r, k_r;
  logic [IDX_W-1:0] r_nxt, c_nxt, k_nxt;
  logic             advance, issue, start;
  logic             out_valid_r;

  // whole pipe holds while a result waits in a stalled output register
  assign advance = !(out_valid_r && out_stall);
  assign start   = in_acc && (fpm3_action_t'(in_action) == ACT_MULTIPLY);
  assign issue   = (state_r == ST_RUN) && advance;
  assign in_stall = (state_r == ST_RUN);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      r_r     <= '0;
      c_r     <= '0;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      r_r     <= r_nxt;
      c_r     <= c_nxt;
      k_r     <= k_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    r_nxt     = r_r;
    c_nxt     = c_r;
    k_nxt     = k_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_RUN;
          r_nxt     = '0;
          c_nxt     = '0;
          k_nxt     = '0;
        end
      end
      ST_RUN: begin
        if (issue) begin
          if (k_r != LAST_IDX) begin
            k_nxt = k_r + 1'b1;
          end else begin
            k_nxt = '0;
            if (c_r != LAST_IDX) begin
              c_nxt = c_r + 1'b1;
            end else begin
              c_nxt = '0;
              if (r_r != LAST_IDX) begin
                r_nxt = r_r + 1'b1;
              end else begin
                state_nxt = ST_IDLE;
              end
            end
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // ---------------- MAC pipeline ----------------
  logic                 v1_r, v2_r;
  fpm3_tag_t            tag1_r, tag2_r, tag_issue;
  logic signed [EW-1:0] a_op_r, b_op_r;
  logic signed [PW-1:0] prod_r;

  assign tag_issue.row       = r_r;
  assign tag_issue.col       = c_r;
  assign tag_issue.first     = (k_r == '0);
  assign tag_issue.elem_last = (k_r == LAST_IDX);
  assign tag_issue.mat_last  = (k_r == LAST_IDX) && (c_r == LAST_IDX) && (r_r == LAST_IDX);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (advance) begin
      v1_r <= issue;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      if (issue) begin
        a_op_r <= a_mem[cell_idx(r_r, k_r)];
        b_op_r <= b_mem[cell_idx(k_r, c_r)];
      end
      tag1_r <= tag_issue;
      prod_r <= a_op_r * b_op_r;
      tag2_r <= tag1_r;
    end
  end

  // fraction conversion: A+B fraction bits down or up to result fraction bits
  logic [SHIFT_W-1:0]       inter_bits, res_bits, rshift, lshift;
  logic                     drop;
  logic signed [PROD_W-1:0] p_ext, p_rs, p_ls;
  logic [EW-1:0]            shifted, acc_sum;
  logic [EW-1:0]            acc_r;

  assign inter_bits = SHIFT_W'(a_frac_r) + SHIFT_W'(b_frac_r);
  assign res_bits   = SHIFT_W'(res_frac_r);
  assign drop       = inter_bits > res_bits;
  assign rshift     = inter_bits - res_bits;
  assign lshift     = res_bits - inter_bits;
  assign p_ext      = PROD_W'(prod_r);
  assign p_rs       = p_ext >>> rshift;
  assign p_ls       = p_ext << lshift;
  assign shifted    = drop ? EW'(p_rs) : EW'(p_ls);
  assign acc_sum    = (tag2_r.first ? '0 : acc_r) + shifted;

  always_ff @(posedge clk) begin
    if (advance && v2_r) begin
      acc_r <= acc_sum;
    end
  end

  // ---------------- output register ----------------
  logic                 out_last_r;
  logic [IDX_W-1:0]     out_row_r, out_col_r;
  logic signed [EW-1:0] out_value_r;
  logic                 res_done;

  assign res_done = advance && v2_r && tag2_r.elem_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_done) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_done) begin
      out_row_r   <= tag2_r.row;
      out_col_r   <= tag2_r.col;
      out_last_r  <= tag2_r.mat_last;
      out_value_r <= acc_sum;
    end
  end

  assign out_valid = out_valid_r;
  assign out_row   = out_row_r;
  assign out_col   = out_col_r;
  assign out_last  = out_last_r;
  assign out_value = FIELD_W'(out_value_r);

  // ---------------- assertions ----------------
  a_last_is_corner: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |-> (out_row == LAST_IDX && out_col == LAST_IDX))
    else $error("last flag on a result that is not the final corner");

  a_multiply_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> in_stall)
    else $error("input not stalled after a multiply request");

  // a new multiply may still be taken while the last result waits
  a_pipe_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (!advance && !start) |=>
      ($stable(v1_r) && $stable(v2_r) && $stable(r_r) && $stable(k_r)))
    else $error("MAC pipeline moved while the output was stalled");

  a_no_issue_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r && advance && $past(state_r) == ST_IDLE && $past(advance)) |-> 0)
    else $error("product issued while the sequencer was idle");

endmodule

// ===== sim/fixed_point_matrix3_multiply_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_point_matrix3_multiply_top_tb: self-checking bench for the 3x3 multiply
// Loads A and B, requests products under several fraction settings, predicts
// the nine elements of each product and checks the result stream in order.
// ----------------------------------------------------------------------------
module fixed_point_matrix3_multiply_top_tb;
  import fpm3_pkg::*;

  localparam int LIMIT_CYCLES    = 400_000;
  localparam int SETTLE_CYCLES   = 12;
  localparam int PHASES          = 8;
  localparam int ITEMS_PER_PHASE = 63;
  localparam int DIRECTED_N      = 25;

  typedef struct packed {
    fpm3_action_t     act;
    fpm3_matrix_t     which;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic [FIELD_W-1:0] value;
    logic             has_exp;     // all nine elements equal exp_value
    logic [FIELD_W-1:0] exp_value;
  } request_t;

  typedef struct packed {
    logic [IDX_W-1:0]   row;
    logic [IDX_W-1:0]   col;
    logic [FIELD_W-1:0] value;
    logic               last;
  } c_elem_t;

  logic clk;
  logic rst_n = 1'b0;

  logic                      in_valid        = 1'b0;
  logic                      in_stall;
  logic                      in_action       = 1'b0;
  logic                      in_which_matrix = 1'b0;
  logic [IDX_W-1:0]          in_row_index    = '0;
  logic [IDX_W-1:0]          in_col_index    = '0;
  logic signed [FIELD_W-1:0] in_element_value = '0;

  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic [IDX_W-1:0]          out_row;
  logic [IDX_W-1:0]          out_col;
  logic signed [FIELD_W-1:0] out_value;
  logic                      out_last;

  logic                  psel    = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite  = 1'b0;
  logic [APB_ADDR_W-1:0] paddr   = '0;
  logic [APB_DATA_W-1:0] pwdata  = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  logic calm = 1'b0;
  int   error_count = 0;
  int   cycle_count = 0;

  // predictor state
  logic [FIELD_W-1:0] a_cells [CELLS];
  logic [FIELD_W-1:0] b_cells [CELLS];
  logic [FRAC_W-1:0]  a_frac   = FRAC_RESET;
  logic [FRAC_W-1:0]  b_frac   = FRAC_RESET;
  logic [FRAC_W-1:0]  res_frac = FRAC_RESET;
  c_elem_t            product_due [$];
  c_elem_t            head;

  // A is full of extremes, B is zero, so the first product is all zero.
  request_t directed_steps [DIRECTED_N] = '{
    '{ACT_LOAD,     MAT_A, 2'd0, 2'd0, 32'h7fff_ffff, 1'b0, 32'h0},
    '{ACT_LOAD,     MAT_A, 2'd0, 2'd1, 32'h8000_0000, 1'b0, 32'h0},
    '{ACT_LOAD,     MAT_A, 2'd0, 2'd2, 32'hffff_ffff, 1'b0, 32'h0},
    '{ACT_LOAD,     MAT_A, 2'd1, 2'd0, 32'h0001_0000, 1'b0, 32'h0},
    '{ACT_LOAD,     MAT_A, 2'd1, 2'd1, 32'h0000_0000, 1'b0, 32'h0},
    '{ACT_LOAD,     MAT_A, 2'd1, 2'd2, 32'h0000_0001, 1'b0, 32'h0},
    '{ACT_LOAD,     MAT_A, 2'd2, 2'd0, 32'hffff_0000, 1'b0, 32'h0},
    '{ACT_LOAD,     MAT_A, 2'd2, 2'd1, 32'h0002_8000, 1'b0, 32'h0},
    '{ACT_LOAD,     MAT_A, 2'd2, 2'd2, 32'h5a5a_a5a5, 1'b0, 32'h0},
    '{ACT_LOAD,     MAT_B, 2'd0, 2'd0, 32'h0,         1'b0, 32'h0},
    '{ACT_LOAD,     MAT_B, 2'd0, 2'd1, 32'h0,         1'b0, 32'h0},
    '{ACT_LOAD,     MAT_B, 2'd0, 2'd2, 32'h0,         1'b0, 32'h0},
    '{ACT_LOAD,     MAT_B, 2'd1, 2'd0, 32'h0,         1'b0, 32'h0},
    '{ACT_LOAD,     MAT_B, 2'd1, 2'd1, 32'h0,         1'b0, 32'h0},
    '{ACT_LOAD,     MAT_B, 2'd1, 2'd2, 32'h0,         1'b0, 32'h0},
    '{ACT_LOAD,     MAT_B, 2'd2, 2'd0, 32'h0,         1'b0, 32'h0},
    '{ACT_LOAD,     MAT_B, 2'd2, 2'd1, 32'h0,         1'b0, 32'h0},
    '{ACT_LOAD,     MAT_B, 2'd2, 2'd2, 32'h0,         1'b0, 32'h0},
    // out-of-matrix loads must leave B at zero
    '{ACT_LOAD,     MAT_B, 2'd0, 2'd3, 32'h7fff_ffff, 1'b0, 32'h0},
    '{ACT_LOAD,     MAT_B, 2'd3, 2'd1, 32'h8000_0000, 1'b0, 32'h0},
    '{ACT_LOAD,     MAT_A, 2'd3, 2'd3, 32'hffff_ffff, 1'b0, 32'h0},
    '{ACT_MULTIPLY, MAT_B, 2'd3, 2'd3, 32'h1234_5678, 1'b1, 32'h0},
    '{ACT_LOAD,     MAT_B, 2'd0, 2'd0, 32'h7fff_ffff, 1'b0, 32'h0},
    '{ACT_LOAD,     MAT_B, 2'd2, 2'd2, 32'h8000_0000, 1'b0, 32'h0},
    '{ACT_MULTIPLY, MAT_A, 2'd0, 2'd0, 32'h0,         1'b0, 32'h0}
  };

  fixed_point_matrix3_multiply_top uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_action        (in_action),
    .in_which_matrix  (in_which_matrix),
    .in_row_index     (in_row_index),
    .in_col_index     (in_col_index),
    .in_element_value (in_element_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_row          (out_row),
    .out_col          (out_col),
    .out_value        (out_value),
    .out_last         (out_last),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAILURE");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    error_count++;
    $display("mismatch %s: got %h expected %h (cycle %0d)", what, got, want, cycle_count);
  endtask

  // One element of C = A * B, each product rescaled before the sum.
  function automatic logic [FIELD_W-1:0] product_element(input int r, input int c);
    logic signed [PROD_W-1:0] x;
    logic signed [PROD_W-1:0] y;
    logic signed [PROD_W-1:0] term;
    logic signed [PROD_W-1:0] acc;
    int unsigned scale_in;
    int unsigned scale_out;
    scale_in  = a_frac + b_frac;
    scale_out = res_frac;
    acc = '0;
    for (int k = 0; k < DIM; k++) begin
      x = $signed(a_cells[r * DIM + k]);
      y = $signed(b_cells[k * DIM + c]);
      term = x * y;
      if (scale_in > scale_out)
        term = term >>> (scale_in - scale_out);
      else
        term = term << (scale_out - scale_in);
      acc = acc + term;
    end
    return acc[FIELD_W-1:0];
  endfunction

  function automatic logic [FIELD_W-1:0] pick_element();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: begin
        case ($urandom_range(0, 4))
          0: return 32'h7fff_ffff;
          1: return 32'h8000_0000;
          2: return 32'hffff_ffff;
          3: return 32'h0;
          default: return 32'h1;
        endcase
      end
      default: return 32'($signed($urandom) >>> $urandom_range(4, 30));
    endcase
  endfunction

  task automatic send_request(input request_t s);
    c_elem_t e;
    int idx;
    while (!calm && $urandom_range(0, 99) < 7) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_action        <= s.act;
    in_which_matrix  <= s.which;
    in_row_index     <= s.row;
    in_col_index     <= s.col;
    in_element_value <= s.value;
    do @(posedge clk); while (in_stall);
    if (s.act == ACT_LOAD) begin
      if (s.row <= LAST_IDX && s.col <= LAST_IDX) begin
        idx = int'(s.row) * DIM + int'(s.col);
        if (s.which == MAT_A) a_cells[idx] = s.value;
        else                  b_cells[idx] = s.value;
      end
    end else begin
      for (int r = 0; r < DIM; r++) begin
        for (int c = 0; c < DIM; c++) begin
          e.row   = IDX_W'(r);
          e.col   = IDX_W'(c);
          e.value = s.has_exp ? s.exp_value : product_element(r, c);
          e.last  = (r == DIM - 1) && (c == DIM - 1);
          product_due.push_back(e);
        end
      end
    end
  endtask

  task automatic apb_access(input logic is_write, input fpm3_reg_t sel,
                            input logic [APB_DATA_W-1:0] wdata,
                            output logic [APB_DATA_W-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= is_write;
    paddr   <= {sel, 2'b00};
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_fraction(input fpm3_reg_t sel, input logic [FRAC_W-1:0] frac);
    logic [APB_DATA_W-1:0] rd;
    // junk in the upper bits; only the low five are kept
    apb_access(1'b1, sel, {27'($urandom), frac}, rd);
    case (sel)
      REG_A_FRAC:   a_frac   = frac;
      REG_B_FRAC:   b_frac   = frac;
      REG_RES_FRAC: res_frac = frac;
      default: ;
    endcase
    if (sel != REG_NONE) begin
      apb_access(1'b0, sel, '0, rd);
      if (rd !== APB_DATA_W'(frac)) report_mismatch("fraction readback", rd, 32'(frac));
    end
  endtask

  // idle only once nothing is pending and the sequencer has had time to finish
  task automatic wait_idle();
    while (product_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  always @(posedge clk) out_stall <= !calm && ($urandom_range(0, 99) < 7);

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (product_due.size() == 0) begin
        report_mismatch("result with nothing pending", out_value, '0);
      end else begin
        head = product_due.pop_front();
        if (out_row !== head.row)     report_mismatch("out_row", 32'(out_row), 32'(head.row));
        if (out_col !== head.col)     report_mismatch("out_col", 32'(out_col), 32'(head.col));
        if (out_value !== head.value) report_mismatch("out_value", out_value, head.value);
        if (out_last !== head.last)   report_mismatch("out_last", 32'(out_last), 32'(head.last));
      end
    end
  end

  initial begin
    logic [APB_DATA_W-1:0] rd;
    logic [FRAC_W-1:0]     fa;
    logic [FRAC_W-1:0]     fb;
    logic [FRAC_W-1:0]     fr;
    request_t              s;
    int                    roll;
    int                    counted;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < 3; i++) begin
      apb_access(1'b0, fpm3_reg_t'(i), '0, rd);
      if (rd !== APB_DATA_W'(FRAC_RESET)) report_mismatch("fraction after reset", rd, 32'd16);
    end

    for (int i = 0; i < DIRECTED_N; i++) send_request(directed_steps[i]);
    in_valid <= 1'b0;

    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      case (p)
        0: {fa, fb, fr} = {5'd0, 5'd0, 5'd0};
        1: {fa, fb, fr} = {5'd31, 5'd31, 5'd31};
        2: {fa, fb, fr} = {5'd31, 5'd31, 5'd0};
        3: {fa, fb, fr} = {5'd0, 5'd0, 5'd31};
        4: {fa, fb, fr} = {5'd16, 5'd8, 5'd24};
        default: begin
          fa = FRAC_W'($urandom_range(0, 31));
          fb = FRAC_W'($urandom_range(0, 31));
          fr = FRAC_W'($urandom_range(0, 31));
        end
      endcase
      set_fraction(REG_A_FRAC, fa);
      set_fraction(REG_B_FRAC, fb);
      set_fraction(REG_RES_FRAC, fr);
      if (p == 2) set_fraction(REG_NONE, 5'd7);
      calm <= (p == 4);

      counted = 0;
      while (counted < ITEMS_PER_PHASE) begin
        roll      = $urandom_range(0, 99);
        s.act     = (roll < 15) ? ACT_MULTIPLY : ACT_LOAD;
        s.which   = fpm3_matrix_t'($urandom_range(0, 1));
        s.row     = IDX_W'($urandom_range(0, 2));
        s.col     = IDX_W'($urandom_range(0, 2));
        s.value   = pick_element();
        s.has_exp = 1'b0;
        s.exp_value = '0;
        if (s.act == ACT_MULTIPLY) begin
          s.row = IDX_W'($urandom_range(0, 3));
          s.col = IDX_W'($urandom_range(0, 3));
        end else if (roll < 23) begin
          // load outside the matrix, dropped by the block
          case ($urandom_range(0, 2))
            0: s.row = 2'd3;
            1: s.col = 2'd3;
            default: {s.row, s.col} = 4'hf;
          endcase
        end
        send_request(s);
        if (roll < 15 || roll >= 23) counted++;
      end
      in_valid <= 1'b0;
    end

    wait_idle();
    if (error_count == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

// ===== fixed_point_matrix3_multiply_top.f =====
design/fpm3_pkg.sv
design/fixed_point_matrix3_multiply_top.sv
sim/fixed_point_matrix3_multiply_top_tb.sv
